// File: design/mssd_pkg.sv
// ----------------------------------------------------------------------------
// mssd_pkg
// Shared widths, reciprocal constants and segment table for the four-digit
// multiplexed seven-segment driver.
// ----------------------------------------------------------------------------
package mssd_pkg;

    localparam int NUM_W   = 16;
    localparam int MOD_W   = 14;
    localparam int SEG_W   = 7;
    localparam int DIGITS  = 4;
    localparam int POS_W   = 2;
    localparam int PROD_W  = 28;

    typedef logic [NUM_W-1:0]  t_number;
    typedef logic [MOD_W-1:0]  t_mod;
    typedef logic [SEG_W-1:0]  t_seg;
    typedef logic [DIGITS-1:0] t_enable;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [3:0]        t_digit;

    // symbol codes: zero and the codes beyond the decimal digits
    localparam t_digit SYM_ZERO = 4'd0;
    localparam t_digit SYM_O    = 4'd10;
    localparam t_digit SYM_F    = 4'd11;

    localparam t_pos POS_FIRST  = 2'd0;
    localparam t_pos POS_SECOND = 2'd1;
    localparam t_pos POS_THIRD  = 2'd2;
    localparam t_pos POS_LAST   = 2'd3;

    // m / 1000 = (m * 8389) >> 23, m / 100 = (m * 10486) >> 20,
    // m / 10 = (m * 13108) >> 17, exact for m < 10000
    localparam logic [PROD_W-1:0] RECIP_1000 = 28'd8389;
    localparam logic [PROD_W-1:0] RECIP_100  = 28'd10486;
    localparam logic [PROD_W-1:0] RECIP_10   = 28'd13108;

    function automatic t_seg seg_code(input t_digit d);
        t_seg s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            SYM_O:   s = 7'h3F;
            SYM_F:   s = 7'h71;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// File: design/multiplexed_seven_segment_driver.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver
// Four-digit multiplexed display scan: decimal split, leading-zero blanking
// and segment decode, one refresh tick per word.
// ----------------------------------------------------------------------------
// Path from accepted word to result valid: input register, then mod 10000,
//   quotient multipliers, digit/enable/segment output register.
// Throughput: one word per cycle while i_stall is low; a stage advances whenever the next one moves.
// Reset: synchronous, active low; clears valids, scan position and enables.
module multiplexed_seven_segment_driver (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  mssd_pkg::t_number       i_number_value,
    input  logic                    i_running,
    output logic                    o_valid,
    input  logic                    i_stall,
    output mssd_pkg::t_seg          o_segment_bits,
    output mssd_pkg::t_enable       o_digit_enable,
    output mssd_pkg::t_pos          o_scan_position
);
    import mssd_pkg::*;

    // pipeline control
    logic en1, en2, en3, out_en, s3_fire;
    logic r_v1, r_v2, r_v3, r_out_valid;

    // stage payloads
    t_number r_num;
    logic    r_run1, r_run2, r_run3;
    t_mod    r_m2, r_m3;
    logic [3:0] r_q1;
    logic [6:0] r_q2;
    logic [9:0] r_q3;

    // scan state
    t_pos    r_scan, n_scan;
    t_enable r_en, n_en;

    // output registers
    t_seg    r_seg;
    t_enable r_out_en;
    t_pos    r_out_pos;

    assign out_en  = !r_out_valid || !i_stall;
    assign en3     = !r_v3 || out_en;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign s3_fire = r_v3 && out_en;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1)    r_v1        <= i_valid;
            if (en2)    r_v2        <= r_v1;
            if (en3)    r_v3        <= r_v2;
            if (out_en) r_out_valid <= r_v3;
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_num  <= i_number_value;
            r_run1 <= i_running;
        end
    end

    // stage 2: number mod 10000 by range select
    t_mod n_m;
    always_comb begin
        priority if (r_num >= 16'd60000) n_m = MOD_W'(r_num - 16'd60000);
        else if (r_num >= 16'd50000)     n_m = MOD_W'(r_num - 16'd50000);
        else if (r_num >= 16'd40000)     n_m = MOD_W'(r_num - 16'd40000);
        else if (r_num >= 16'd30000)     n_m = MOD_W'(r_num - 16'd30000);
        else if (r_num >= 16'd20000)     n_m = MOD_W'(r_num - 16'd20000);
        else if (r_num >= 16'd10000)     n_m = MOD_W'(r_num - 16'd10000);
        else                             n_m = MOD_W'(r_num);
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_m2   <= n_m;
            r_run2 <= r_run1;
        end
    end

    // stage 3: quotients by reciprocal multiply
    logic [PROD_W-1:0] p1000, p100, p10;
    assign p1000 = PROD_W'(r_m2) * RECIP_1000;
    assign p100  = PROD_W'(r_m2) * RECIP_100;
    assign p10   = PROD_W'(r_m2) * RECIP_10;

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_q1   <= p1000[26:23];
            r_q2   <= p100[26:20];
            r_q3   <= p10[26:17];
            r_m3   <= r_m2;
            r_run3 <= r_run2;
        end
    end

    // output stage: digits, enable update, segment decode
    logic [6:0]  d1_w;
    logic [9:0]  d2_w;
    t_mod        d3_w;
    t_digit      dig [DIGITS];
    t_digit      cur;

    assign d1_w = r_q2 - ((7'(r_q1)) << 3) - ((7'(r_q1)) << 1);
    assign d2_w = r_q3 - ((10'(r_q2)) << 3) - ((10'(r_q2)) << 1);
    assign d3_w = r_m3 - ((MOD_W'(r_q3)) << 3) - ((MOD_W'(r_q3)) << 1);

    always_comb begin
        if (r_run3) begin
            dig[0] = r_q1;
            dig[1] = d1_w[3:0];
            dig[2] = d2_w[3:0];
            dig[3] = d3_w[3:0];
        end else begin
            dig[0] = SYM_ZERO;
            dig[1] = SYM_O;
            dig[2] = SYM_F;
            dig[3] = SYM_F;
        end

        n_scan = r_scan + 2'd1;
        n_en   = r_en;
        unique case (n_scan)
            POS_FIRST: begin
                if (dig[0] != SYM_ZERO) n_en[0] = 1'b1;
                n_en[3] = 1'b0;
            end
            POS_SECOND: begin
                if (dig[0] != SYM_ZERO || dig[1] != SYM_ZERO) n_en[1] = 1'b1;
                n_en[0] = 1'b0;
            end
            POS_THIRD: begin
                if (dig[0] != SYM_ZERO || dig[1] != SYM_ZERO || dig[2] != SYM_ZERO)
                    n_en[2] = 1'b1;
                n_en[1] = 1'b0;
            end
            POS_LAST: begin
                n_en[2] = 1'b0;
                n_en[3] = 1'b1;
            end
            default: n_en = r_en;
        endcase
        cur = dig[n_scan];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= POS_FIRST;
            r_en   <= '0;
        end else if (s3_fire) begin
            r_scan <= n_scan;
            r_en   <= n_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_fire) begin
            r_seg     <= seg_code(cur);
            r_out_en  <= n_en;
            r_out_pos <= n_scan;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_segment_bits  = r_seg;
    assign o_digit_enable  = r_out_en;
    assign o_scan_position = r_out_pos;

    // scan position steps by one per tick through the last stage
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s3_fire |=> r_scan == $past(r_scan) + 2'd1)
        else $error("scan position did not advance by one");

    // last digit is always lit when refreshed
    a_last_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_scan_position == POS_LAST) |-> o_digit_enable[3])
        else $error("last digit not enabled on its refresh");

    // previous position is dark after each refresh
    a_prev_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_digit_enable[o_scan_position - 2'd1])
        else $error("previous digit enable not cleared");

    // an empty input register never holds off the source
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("stall raised with empty input stage");

endmodule
